@@ src/assert_macros.svh @@
// Assertion macros for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion clocked on the rising edge, disabled while reset is low.
`define GWES_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same check with no reset qualifier, for properties that hold through reset.
`define GWES_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/gwes_pkg.sv @@
// Types and constants for the grid window energy sum/max unit.
`timescale 1ns / 1ps

package gwes_pkg;

  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 9;
  localparam int unsigned ETA_BITS      = 8;
  localparam int unsigned PHI_BITS      = 9;
  localparam int unsigned GRID_BITS     = 8;
  localparam int unsigned MAXE_BITS     = 23;
  localparam int unsigned ID_BITS       = 32;
  localparam int unsigned WSUM_BITS     = 32;

  localparam logic [GRID_BITS-1:0] GRID_SIZE_RESET  = 8'd1;
  localparam logic [PHI_BITS-1:0]  PHI_CELLS_LATTICE = 9'd72;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CENTER_ETA_OR_X = 3'd0,
    REG_CENTER_PHI_OR_Y = 3'd1,
    REG_CENTER_SIDE     = 3'd2,
    REG_GRID_SIZE       = 3'd3,
    REG_PHI_PERIOD      = 3'd4,
    REG_WINDOW_MODE     = 3'd5,
    REG_CENTER_PRESENT  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [ETA_BITS-1:0]  center_eta_or_x;  // two's complement
    logic [PHI_BITS-1:0]  center_phi_or_y;
    logic                 center_side;
    logic [GRID_BITS-1:0] grid_size;
    logic [PHI_BITS-1:0]  phi_period;
    logic                 window_mode;
    logic                 center_present;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    center_eta_or_x: '0,
    center_phi_or_y: '0,
    center_side:     1'b0,
    grid_size:       GRID_SIZE_RESET,
    phi_period:      PHI_CELLS_LATTICE,
    window_mode:     1'b0,
    center_present:  1'b0
  };

  typedef struct packed {
    logic                first_hit;
    logic [ETA_BITS-1:0] eta_or_x;  // two's complement
    logic [PHI_BITS-1:0] phi_or_y;
    logic                side;
    logic                same_system;
  } hit_t;

endpackage

@@ src/gwes_window.sv @@
// Window membership test of one hit against the configured center cell.
`timescale 1ns / 1ps

module gwes_window (
  input  gwes_pkg::cfg_t cfg_i,
  input  gwes_pkg::hit_t hit_i,
  output logic           in_win_o
);
  import gwes_pkg::*;

  logic [ETA_BITS:0]   ce_ext, ne_ext, ce_adj, ne_adj;
  logic [ETA_BITS+1:0] de_s, de_mag;
  logic [PHI_BITS:0]   dp_s, dp_mag, pd_s, pd_mag, dph;
  logic [ETA_BITS:0]   dx_s, dx_mag;
  logic                lattice_in, endcap_in;

  always_comb begin
    // lattice eta: negative indices move up by one (no zero cell)
    ce_ext = {cfg_i.center_eta_or_x[ETA_BITS-1], cfg_i.center_eta_or_x};
    ne_ext = {hit_i.eta_or_x[ETA_BITS-1], hit_i.eta_or_x};
    ce_adj = cfg_i.center_eta_or_x[ETA_BITS-1] ? ce_ext + 1'b1 : ce_ext;
    ne_adj = hit_i.eta_or_x[ETA_BITS-1] ? ne_ext + 1'b1 : ne_ext;
    de_s   = {ce_adj[ETA_BITS], ce_adj} - {ne_adj[ETA_BITS], ne_adj};
    de_mag = de_s[ETA_BITS+1] ? (~de_s + 1'b1) : de_s;

    // phi / y distance, shared by both modes
    dp_s   = {1'b0, cfg_i.center_phi_or_y} - {1'b0, hit_i.phi_or_y};
    dp_mag = dp_s[PHI_BITS] ? (~dp_s + 1'b1) : dp_s;

    // wrapped distance period - d; only its magnitude matters
    pd_s   = {1'b0, cfg_i.phi_period} - dp_mag;
    pd_mag = pd_s[PHI_BITS] ? (~pd_s + 1'b1) : pd_s;
    dph    = (pd_mag < dp_mag) ? pd_mag : dp_mag;

    lattice_in = (de_mag <= {2'b00, cfg_i.grid_size}) &&
                 (dph <= {2'b00, cfg_i.grid_size});

    dx_s   = {cfg_i.center_eta_or_x[ETA_BITS-1], cfg_i.center_eta_or_x} - ne_ext;
    dx_mag = dx_s[ETA_BITS] ? (~dx_s + 1'b1) : dx_s;

    endcap_in = (hit_i.side == cfg_i.center_side) &&
                (dx_mag <= {1'b0, cfg_i.grid_size}) &&
                (dp_mag <= {2'b00, cfg_i.grid_size});

    in_win_o = cfg_i.window_mode ? endcap_in : lattice_in;
  end

endmodule

@@ src/gwes_accum.sv @@
// Running saturating window sum and strict-greater maximum tracker.
`timescale 1ns / 1ps

module gwes_accum #(
  parameter int unsigned ENERGY_BITS = 24,
  parameter int unsigned SUM_BITS    = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  logic                                first_i,
  input  logic                                use_i,
  input  logic                                present_i,
  input  logic signed [ENERGY_BITS-1:0]       energy_i,
  input  logic [gwes_pkg::ID_BITS-1:0]        id_i,
  output logic [gwes_pkg::WSUM_BITS-1:0]      window_sum_o,
  output logic [gwes_pkg::MAXE_BITS-1:0]      max_energy_o,
  output logic [gwes_pkg::ID_BITS-1:0]        max_id_o,
  output logic                                max_found_o
);
  import gwes_pkg::*;

  localparam int unsigned ADD_W = ((SUM_BITS > ENERGY_BITS) ? SUM_BITS : ENERGY_BITS) + 1;
  localparam int unsigned CMP_W = ((ENERGY_BITS > MAXE_BITS) ? ENERGY_BITS : MAXE_BITS) + 1;
  localparam int unsigned WS_W  = (SUM_BITS > WSUM_BITS) ? SUM_BITS : WSUM_BITS;

  localparam logic [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};
  localparam logic signed [CMP_W-1:0] MAXE_LIMIT = CMP_W'({MAXE_BITS{1'b1}});

  logic signed [SUM_BITS-1:0]   sum_q, sum_d, sum_base;
  logic [MAXE_BITS-1:0]         maxe_q, maxe_d, maxe_base;
  logic [ID_BITS-1:0]           maxid_q, maxid_d, maxid_base;
  logic                         found_q, found_d, found_base;
  logic                         zero_q, zero_d;

  logic signed [ADD_W-1:0]      sum_wide;
  logic [ADD_W-SUM_BITS:0]      sum_hi;
  logic [SUM_BITS-1:0]          sum_sat;
  logic signed [CMP_W-1:0]      e_cmp, m_cmp;
  logic                         gt;
  logic [MAXE_BITS-1:0]         e_sat;
  logic signed [WS_W-1:0]       ws_ext;

  always_comb begin
    // first hit of a group clears before the hit is applied
    sum_base   = first_i ? '0 : sum_q;
    maxe_base  = first_i ? '0 : maxe_q;
    maxid_base = first_i ? '0 : maxid_q;
    found_base = first_i ? 1'b0 : found_q;

    sum_wide = ADD_W'(sum_base) + ADD_W'(energy_i);
    sum_hi   = sum_wide[ADD_W-1:SUM_BITS-1];
    if ((&sum_hi) || !(|sum_hi)) begin
      sum_sat = sum_wide[SUM_BITS-1:0];
    end else begin
      sum_sat = sum_wide[ADD_W-1] ? SUM_MIN : SUM_MAX;
    end

    e_cmp = CMP_W'(energy_i);
    m_cmp = $signed(CMP_W'(maxe_base));
    gt    = e_cmp > m_cmp;
    e_sat = (e_cmp > MAXE_LIMIT) ? {MAXE_BITS{1'b1}} : e_cmp[MAXE_BITS-1:0];

    sum_d   = sum_base;
    maxe_d  = maxe_base;
    maxid_d = maxid_base;
    found_d = found_base;
    zero_d  = !present_i;
    if (present_i && use_i) begin
      sum_d = sum_sat;
      if (gt) begin
        maxe_d  = e_sat;
        maxid_d = id_i;
        found_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      maxe_q  <= '0;
      maxid_q <= '0;
      found_q <= 1'b0;
      zero_q  <= 1'b1;
    end else if (load_i) begin
      sum_q   <= sum_d;
      maxe_q  <= maxe_d;
      maxid_q <= maxid_d;
      found_q <= found_d;
      zero_q  <= zero_d;
    end
  end

  always_comb begin
    ws_ext       = WS_W'(sum_q);
    window_sum_o = zero_q ? '0 : ws_ext[WSUM_BITS-1:0];
    max_energy_o = zero_q ? '0 : maxe_q;
    max_id_o     = zero_q ? '0 : maxid_q;
    max_found_o  = zero_q ? 1'b0 : found_q;
  end

endmodule

@@ src/grid_window_energy_sum_max_unit.sv @@
// Top level: input stage, configuration registers and output flow control.
`timescale 1ns / 1ps

// Square-window energy sum and maximum over a stream of calorimeter hits. Each
// accepted hit yields one result: it is held in the input register, then the
// window test and the saturating accumulate/compare land in the result register.
// One hit per cycle is sustained while the input is not stalled; the feedback
// through the running sum and maximum registers allows that rate. The input
// stalls only while both stages are full and the output is stalled. Configuration
// writes are always ready and must be done while no transaction is in flight.
module grid_window_energy_sum_max_unit #(
  parameter int unsigned ENERGY_BITS = 24,
  parameter int unsigned SUM_BITS    = 32
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,

  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [gwes_pkg::CFG_IDX_BITS-1:0]        cfg_index_i,
  input  logic [gwes_pkg::CFG_DATA_BITS-1:0]       cfg_data_i,

  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic                                     first_hit_i,
  input  logic signed [gwes_pkg::ETA_BITS-1:0]     hit_eta_or_x_i,
  input  logic [gwes_pkg::PHI_BITS-1:0]            hit_phi_or_y_i,
  input  logic                                     hit_side_i,
  input  logic                                     hit_same_system_i,
  input  logic signed [ENERGY_BITS-1:0]            hit_energy_i,
  input  logic [gwes_pkg::ID_BITS-1:0]             hit_id_i,

  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic signed [gwes_pkg::WSUM_BITS-1:0]    window_sum_o,
  output logic [gwes_pkg::MAXE_BITS-1:0]           max_energy_o,
  output logic [gwes_pkg::ID_BITS-1:0]             max_id_o,
  output logic                                     max_found_o
);
  import gwes_pkg::*;

  cfg_t                         cfg_q;
  hit_t                         hit_q;
  logic signed [ENERGY_BITS-1:0] energy_q;
  logic [ID_BITS-1:0]           id_q;
  logic                         v1_q, v1_d;
  logic                         out_valid_q, out_valid_d;
  logic                         out_free, move, accept, in_win;
  logic [WSUM_BITS-1:0]         window_sum;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_CENTER_ETA_OR_X: cfg_q.center_eta_or_x <= cfg_data_i[ETA_BITS-1:0];
        REG_CENTER_PHI_OR_Y: cfg_q.center_phi_or_y <= cfg_data_i[PHI_BITS-1:0];
        REG_CENTER_SIDE:     cfg_q.center_side     <= cfg_data_i[0];
        REG_GRID_SIZE:       cfg_q.grid_size       <= cfg_data_i[GRID_BITS-1:0];
        REG_PHI_PERIOD:      cfg_q.phi_period      <= cfg_data_i[PHI_BITS-1:0];
        REG_WINDOW_MODE:     cfg_q.window_mode     <= cfg_data_i[0];
        REG_CENTER_PRESENT:  cfg_q.center_present  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // two-stage flow control: input register, then result register
  always_comb begin
    out_free    = !out_valid_q || !out_stall_i;
    move        = v1_q && out_free;
    in_stall_o  = v1_q && !out_free;
    accept      = in_valid_i && !in_stall_o;
    v1_d        = accept || (v1_q && !move);
    out_valid_d = move || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q        <= v1_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hit_q.first_hit   <= first_hit_i;
      hit_q.eta_or_x    <= hit_eta_or_x_i;
      hit_q.phi_or_y    <= hit_phi_or_y_i;
      hit_q.side        <= hit_side_i;
      hit_q.same_system <= hit_same_system_i;
      energy_q          <= hit_energy_i;
      id_q              <= hit_id_i;
    end
  end

  gwes_window u_window (
    .cfg_i    (cfg_q),
    .hit_i    (hit_q),
    .in_win_o (in_win)
  );

  gwes_accum #(
    .ENERGY_BITS (ENERGY_BITS),
    .SUM_BITS    (SUM_BITS)
  ) u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (move),
    .first_i      (hit_q.first_hit),
    .use_i        (hit_q.same_system && in_win),
    .present_i    (cfg_q.center_present),
    .energy_i     (energy_q),
    .id_i         (id_q),
    .window_sum_o (window_sum),
    .max_energy_o (max_energy_o),
    .max_id_o     (max_id_o),
    .max_found_o  (max_found_o)
  );

  assign window_sum_o = $signed(window_sum);
  assign out_valid_o  = out_valid_q;

endmodule

@@ src/gwes_checker.sv @@
// Port-level checker for the grid window energy sum/max unit, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gwes_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic signed [gwes_pkg::WSUM_BITS-1:0] window_sum_o,
  input logic [gwes_pkg::MAXE_BITS-1:0]        max_energy_o,
  input logic [gwes_pkg::ID_BITS-1:0]          max_id_o,
  input logic                                  max_found_o
);

  // a stalled result stays valid, and its window sum and max id stay unchanged
  `GWES_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "stalled result dropped")
  `GWES_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(window_sum_o) && $stable(max_id_o), "stalled result changed")

  // out_valid is high once an accepted hit has passed the input and result registers
  `GWES_ASSERT(a_latency, clk_i, rst_ni, in_valid_i && !in_stall_o |=> ##1 out_valid_o, "accepted hit produced no result")

  // no maximum found means energy and id stay at zero; a found maximum is positive
  `GWES_ASSERT(a_no_max_zero, clk_i, rst_ni, out_valid_o && !max_found_o |-> max_energy_o == '0 && max_id_o == '0, "maximum fields set without a found maximum")
  `GWES_ASSERT(a_max_positive, clk_i, rst_ni, out_valid_o && max_found_o |-> max_energy_o != '0, "found maximum with zero energy")

endmodule

bind grid_window_energy_sum_max_unit gwes_checker u_gwes_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .window_sum_o (window_sum_o),
  .max_energy_o (max_energy_o),
  .max_id_o     (max_id_o),
  .max_found_o  (max_found_o)
);

@@ dv/grid_window_energy_sum_max_unit_test.sv @@
// Self-checking testbench for the grid window energy sum/max unit.
`timescale 1ns / 1ps

module grid_window_energy_sum_max_unit_test;
  import gwes_pkg::*;

  localparam int unsigned ENERGY_W = 24;
  localparam int unsigned SUM_W = 32;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED = 3'd7;
  localparam int unsigned IDLE_PCT = 29;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_PRINTED = 40;
  localparam logic [MAXE_BITS-1:0] PEAK_LIMIT = '1;
  localparam longint SUM_HI = (longint'(1) << (SUM_W - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam logic [ENERGY_W-1:0] E_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
  localparam logic [ENERGY_W-1:0] E_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};

  typedef struct packed {
    hit_t                hdr;
    logic [ENERGY_W-1:0] energy;  // two's complement
    logic [ID_BITS-1:0]  id;
  } calo_hit_t;

  typedef struct packed {
    logic [WSUM_BITS-1:0] window_sum;
    logic [MAXE_BITS-1:0] max_energy;
    logic [ID_BITS-1:0]   max_id;
    logic                 max_found;
  } window_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic first_hit_i = 1'b0;
  logic signed [ETA_BITS-1:0] hit_eta_or_x_i = '0;
  logic [PHI_BITS-1:0] hit_phi_or_y_i = '0;
  logic hit_side_i = 1'b0;
  logic hit_same_system_i = 1'b0;
  logic signed [ENERGY_W-1:0] hit_energy_i = '0;
  logic [ID_BITS-1:0] hit_id_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [WSUM_BITS-1:0] window_sum_o;
  logic [MAXE_BITS-1:0] max_energy_o;
  logic [ID_BITS-1:0] max_id_o;
  logic max_found_o;

  // Shadow copy of the configuration and the running window state
  cfg_t shadow_cfg = CFG_RESET;
  longint acc_sum = 0;
  logic [MAXE_BITS-1:0] peak_energy = '0;
  logic [ID_BITS-1:0] peak_id = '0;
  logic peak_found = 1'b0;

  window_result_t pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned in_idle_pct = IDLE_PCT;
  int unsigned out_idle_pct = IDLE_PCT;

  grid_window_energy_sum_max_unit #(
    .ENERGY_BITS(ENERGY_W),
    .SUM_BITS   (SUM_W)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .first_hit_i      (first_hit_i),
    .hit_eta_or_x_i   (hit_eta_or_x_i),
    .hit_phi_or_y_i   (hit_phi_or_y_i),
    .hit_side_i       (hit_side_i),
    .hit_same_system_i(hit_same_system_i),
    .hit_energy_i     (hit_energy_i),
    .hit_id_i         (hit_id_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .window_sum_o     (window_sum_o),
    .max_energy_o     (max_energy_o),
    .max_id_o         (max_id_o),
    .max_found_o      (max_found_o)
  );

  always #1 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_idle_pct);
  end

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit hit_in_window(hit_t h);
    longint g, ce, ne, cp, hp, de, dp, p;
    g  = longint'(shadow_cfg.grid_size);
    ce = longint'($signed(shadow_cfg.center_eta_or_x));
    ne = longint'($signed(h.eta_or_x));
    cp = longint'(shadow_cfg.center_phi_or_y);
    hp = longint'(h.phi_or_y);
    if (shadow_cfg.window_mode) begin
      if (h.side != shadow_cfg.center_side) return 1'b0;
      return (mag(ce - ne) <= g) && (mag(cp - hp) <= g);
    end
    // lattice: negative eta is pulled one cell toward zero (no eta index 0 gap)
    if (ce < 0) ce++;
    if (ne < 0) ne++;
    de = mag(ce - ne);
    dp = mag(cp - hp);
    p  = longint'(shadow_cfg.phi_period);
    if (mag(p - dp) < dp) dp = p - dp;
    return (de <= g) && (mag(dp) <= g);
  endfunction

  function automatic window_result_t window_accumulate(calo_hit_t h);
    window_result_t r;
    longint e, s;
    e = longint'($signed(h.energy));
    if (h.hdr.first_hit) begin
      acc_sum = 0;
      peak_energy = '0;
      peak_id = '0;
      peak_found = 1'b0;
    end
    if (!shadow_cfg.center_present) return '0;
    if (h.hdr.same_system && hit_in_window(h.hdr)) begin
      s = acc_sum + e;
      if (s > SUM_HI) s = SUM_HI;
      if (s < SUM_LO) s = SUM_LO;
      acc_sum = s;
      if (e > longint'(peak_energy)) begin
        peak_energy = (e > longint'(PEAK_LIMIT)) ? PEAK_LIMIT : MAXE_BITS'(e);
        peak_id = h.id;
        peak_found = 1'b1;
      end
    end
    r.window_sum = WSUM_BITS'(acc_sum);
    r.max_energy = peak_energy;
    r.max_id = peak_id;
    r.max_found = peak_found;
    return r;
  endfunction

  function automatic void shadow_write(logic [CFG_IDX_BITS-1:0] idx,
                                       logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_CENTER_ETA_OR_X: shadow_cfg.center_eta_or_x = data[ETA_BITS-1:0];
      REG_CENTER_PHI_OR_Y: shadow_cfg.center_phi_or_y = data[PHI_BITS-1:0];
      REG_CENTER_SIDE:     shadow_cfg.center_side = data[0];
      REG_GRID_SIZE:       shadow_cfg.grid_size = data[GRID_BITS-1:0];
      REG_PHI_PERIOD:      shadow_cfg.phi_period = data[PHI_BITS-1:0];
      REG_WINDOW_MODE:     shadow_cfg.window_mode = data[0];
      REG_CENTER_PRESENT:  shadow_cfg.center_present = data[0];
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    if (mismatch_count < MAX_PRINTED)
      $display("%0t mismatch %s: expected %h, got %h", $realtime, what, want, got);
    mismatch_count++;
  endtask

  // Input transactions feed the predictor; output transactions are checked in order
  always @(posedge clk_i) begin
    calo_hit_t seen;
    window_result_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        seen = {first_hit_i, hit_eta_or_x_i, hit_phi_or_y_i, hit_side_i,
                hit_same_system_i, hit_energy_i, hit_id_i};
        pending_results.push_back(window_accumulate(seen));
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", '0, window_sum_o);
        end else begin
          want = pending_results.pop_front();
          if (window_sum_o !== want.window_sum)
            report_mismatch("window_sum", want.window_sum, window_sum_o);
          if (max_energy_o !== want.max_energy)
            report_mismatch("max_energy", want.max_energy, max_energy_o);
          if (max_id_o !== want.max_id)
            report_mismatch("max_id", want.max_id, max_id_o);
          if (max_found_o !== want.max_found)
            report_mismatch("max_found", want.max_found, max_found_o);
        end
      end
      if (cfg_valid_i && cfg_ready_o) shadow_write(cfg_index_i, cfg_data_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // All stimulus tasks start and end just after a falling edge
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_index_i = idx;
    cfg_data_i = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_hit(calo_hit_t h);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    {first_hit_i, hit_eta_or_x_i, hit_phi_or_y_i, hit_side_i, hit_same_system_i,
     hit_energy_i, hit_id_i} = h;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Unused upper data bits are filled with noise; the block must drop them
  task automatic set_window(logic [7:0] eta, logic [8:0] phi, logic side, logic [7:0] grid,
                            logic [8:0] period, logic mode, logic present);
    write_reg(REG_CENTER_ETA_OR_X, {1'($urandom), eta});
    write_reg(REG_CENTER_PHI_OR_Y, phi);
    write_reg(REG_CENTER_SIDE, {8'($urandom), side});
    write_reg(REG_GRID_SIZE, {1'($urandom), grid});
    write_reg(REG_PHI_PERIOD, period);
    write_reg(REG_WINDOW_MODE, {8'($urandom), mode});
    if ($urandom_range(3) == 0) write_reg(REG_UNMAPPED, 9'($urandom));
    write_reg(REG_CENTER_PRESENT, {8'($urandom), present});
  endtask

  function automatic calo_hit_t make_hit(logic first, int eta, int phi, logic side,
                                         logic same, int energy, logic [31:0] id);
    calo_hit_t h;
    h.hdr.first_hit = first;
    h.hdr.eta_or_x = 8'(eta);
    h.hdr.phi_or_y = 9'(phi);
    h.hdr.side = side;
    h.hdr.same_system = same;
    h.energy = ENERGY_W'(energy);
    h.id = id;
    return h;
  endfunction

  function automatic calo_hit_t random_hit();
    calo_hit_t h;
    int span, off, pick;
    h.hdr.first_hit = ($urandom_range(99) < 4);
    h.hdr.eta_or_x = 8'($urandom);
    h.hdr.phi_or_y = 9'($urandom);
    h.hdr.side = 1'($urandom);
    h.hdr.same_system = ($urandom_range(99) < 85);
    h.energy = ENERGY_W'($urandom);
    h.id = $urandom;
    // mostly land around the window edge so both sides of each compare get hit
    span = int'(shadow_cfg.grid_size) + 2;
    if ($urandom_range(99) < 75) begin
      off = int'($urandom_range(2 * span)) - span;
      h.hdr.eta_or_x = shadow_cfg.center_eta_or_x + 8'(off);
      off = int'($urandom_range(2 * span)) - span;
      h.hdr.phi_or_y = shadow_cfg.center_phi_or_y + 9'(off);
      pick = $urandom_range(3);
      if (!shadow_cfg.window_mode && pick == 0) h.hdr.phi_or_y += shadow_cfg.phi_period;
      if (!shadow_cfg.window_mode && pick == 1) h.hdr.phi_or_y -= shadow_cfg.phi_period;
      if (shadow_cfg.window_mode && $urandom_range(99) < 85)
        h.hdr.side = shadow_cfg.center_side;
    end
    pick = $urandom_range(99);
    if (pick < 10) begin
      case ($urandom_range(4))
        0: h.energy = E_MAX;
        1: h.energy = E_MIN;
        2: h.energy = '0;
        3: h.energy = ENERGY_W'(1);
        default: h.energy = '1;
      endcase
    end else if (pick < 70) begin
      h.energy = ENERGY_W'(int'($urandom_range(131072)) - 65536);
    end
    return h;
  endfunction

  task automatic test_no_center();
    send_hit(make_hit(1, 0, 0, 0, 1, 8388607, 32'h0000_1234));
    send_hit(make_hit(0, 1, 1, 0, 1, -5, 32'hFFFF_FFFF));
    wait_idle();
  endtask

  task automatic test_lattice_edges();
    set_window(8'hFF, 9'd0, 1'b0, 8'd1, 9'd72, 1'b0, 1'b1);
    send_hit(make_hit(1, -2, 0, 0, 1, 100, 32'h11));          // folded negative eta
    send_hit(make_hit(0, 1, 71, 0, 1, 8388607, 32'h22));      // phi wraps
    send_hit(make_hit(0, 0, 2, 0, 1, 500, 32'h33));           // just out in phi
    send_hit(make_hit(0, 2, 1, 0, 1, 500, 32'h44));           // just out in eta
    send_hit(make_hit(0, -1, 511, 1, 1, -8388608, 32'h55));   // phi past the period
    send_hit(make_hit(0, 0, 0, 0, 0, 5000, 32'h66));          // other subdetector
    send_hit(make_hit(0, -1, 1, 1, 1, -8388608, 32'h77));
    send_hit(make_hit(0, 0, 0, 0, 1, 0, 32'h88));
    send_hit(make_hit(1, 0, 0, 0, 0, 9, 32'h99));             // clear on a skipped hit
    send_hit(make_hit(0, 0, 1, 0, 1, 1, 32'hFFFF_FFFF));
    send_hit(make_hit(0, -128, 0, 0, 1, 7, 32'hAA));
    send_hit(make_hit(0, 127, 0, 0, 1, 7, 32'hBB));
    wait_idle();
    set_window(8'h00, 9'd0, 1'b0, 8'd2, 9'd0, 1'b0, 1'b1);   // zero period: no wrap
    send_hit(make_hit(1, 0, 511, 0, 1, 40, 32'hCC));
    send_hit(make_hit(0, 0, 2, 0, 1, 41, 32'hDD));
    wait_idle();
  endtask

  task automatic test_endcap_edges();
    set_window(8'h7F, 9'd511, 1'b1, 8'd0, 9'd360, 1'b1, 1'b1);
    send_hit(make_hit(1, 127, 511, 1, 1, 300, 32'h1));
    send_hit(make_hit(0, 127, 511, 0, 1, 300, 32'h2));        // side mismatch
    send_hit(make_hit(0, 127, 510, 1, 1, 300, 32'h3));
    send_hit(make_hit(0, 126, 511, 1, 1, 300, 32'h4));
    wait_idle();
    set_window(8'h80, 9'd0, 1'b0, 8'd255, 9'd1, 1'b1, 1'b1);
    send_hit(make_hit(1, 127, 255, 0, 1, 8388607, 32'h5));    // x distance 255
    send_hit(make_hit(0, 0, 256, 0, 1, 8388607, 32'h6));      // y distance 256
    wait_idle();
  endtask

  task automatic test_random_windows(int unsigned phases, int unsigned items);
    logic [7:0] eta, grid;
    logic [8:0] phi, period;
    for (int unsigned ph = 0; ph < phases; ph++) begin
      case ($urandom_range(4))
        0: grid = 8'd0;
        1: grid = 8'd255;
        2: grid = 8'd1;
        default: grid = 8'($urandom_range(6));
      endcase
      case ($urandom_range(6))
        0: period = 9'd72;
        1: period = 9'd360;
        2: period = 9'd1;
        3: period = 9'd511;
        4: period = 9'd0;
        default: period = 9'($urandom);
      endcase
      eta = (ph == 0) ? 8'h80 : (ph == 1) ? 8'h7F : 8'($urandom);
      phi = (ph == 0) ? 9'd0 : (ph == 1) ? 9'd511 : 9'($urandom);
      set_window(eta, phi, 1'($urandom), grid, period, 1'($urandom),
                 $urandom_range(9) != 0);
      repeat (items) send_hit(random_hit());
      wait_idle();
    end
  endtask

  task automatic test_back_to_back();
    in_idle_pct = 0;
    out_idle_pct = 0;
    test_random_windows(1, 150);
    in_idle_pct = IDLE_PCT;
    out_idle_pct = IDLE_PCT;
  endtask

  // Everything in the window: drive the sum into both rails
  task automatic test_sum_saturation();
    calo_hit_t h;
    int level;
    set_window(8'h00, 9'd100, 1'b0, 8'd255, 9'd72, 1'b1, 1'b1);
    for (int i = 0; i < 900; i++) begin
      h = random_hit();
      h.hdr.first_hit = (i == 0);
      h.hdr.same_system = 1'b1;
      h.hdr.side = 1'b0;
      h.hdr.eta_or_x = 8'($urandom);
      h.hdr.phi_or_y = 9'($urandom_range(355));
      level = $urandom_range(8388607, 8000000);
      h.energy = (i < 300) ? ENERGY_W'(level) : ENERGY_W'(-level);
      send_hit(h);
    end
    wait_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_no_center();
    test_lattice_edges();
    test_endcap_edges();
    test_random_windows(5, 90);
    test_back_to_back();
    test_sum_saturation();
    test_random_windows(5, 90);
    wait_idle();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
